// ===== rtl/core/twcw_pkg.sv =====
// ----------------------------------------------------------------------------
// twcw_pkg
// Shared types and constants for the text window character writer: item kind
// codes, configuration register indexes, character codes, the command that
// travels from the front end to the back end, and the back-end state type.
// ----------------------------------------------------------------------------
package twcw_pkg;

  // Default window storage size
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 256;

  // Character codes with special meaning
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BLANK = 8'd32;

  // Item kind codes as they arrive on the input channel
  localparam int         KIND_W       = 3;
  localparam logic [2:0] KIND_PUT     = 3'd0;
  localparam logic [2:0] KIND_MOVE    = 3'd1;
  localparam logic [2:0] KIND_CLR_EOL = 3'd2;
  localparam logic [2:0] KIND_ERASE   = 3'd3;
  localparam logic [2:0] KIND_READ    = 3'd4;

  // Configuration register indexes and widths
  localparam int         CFG_IDX_W  = 2;
  localparam int         CFG_DATA_W = 9;
  localparam logic [1:0] CFG_ROWS   = 2'd0;
  localparam logic [1:0] CFG_COLS   = 2'd1;
  localparam logic [1:0] CFG_SCROLL = 2'd2;

  localparam int         ROWS_CFG_W = 7;
  localparam int         COLS_CFG_W = 9;
  localparam logic [6:0] ROWS_RESET = 7'd25;
  localparam logic [8:0] COLS_RESET = 9'd80;

  // Entries in the command queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // Operation decided by the front end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CR,
    OP_LF,
    OP_CHAR,
    OP_MOVE,
    OP_CLR_EOL,
    OP_ERASE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_COPY,
    ST_COPY_END,
    ST_READ,
    ST_DONE
  } back_state_t;

endpackage

// ===== rtl/core/twcw_queue.sv =====
// ----------------------------------------------------------------------------
// twcw_queue
// Short first-in first-out queue that decouples the front end from the back
// end. The head entry is visible while valid is high.
// ----------------------------------------------------------------------------
module twcw_queue
  import twcw_pkg::*;
#(
  parameter int WIDTH = CMD_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rp];

  // Track occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CW'(1);
    end else if (pop && !push) begin
      count_next = count - CW'(1);
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + PW'(1);
      end
    end
  end

  // Store pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

endmodule

// ===== rtl/core/twcw_front.sv =====
// ----------------------------------------------------------------------------
// twcw_front
// Front end: accepts input requests, decodes the kind and character code into
// one operation, clamps move targets into the window and turns reads outside
// the window into no-ops. The decoded command waits in a register until the
// queue takes it.
// ----------------------------------------------------------------------------
module twcw_front
  import twcw_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [KIND_W-1:0]           kind,
  input  logic [7:0]                  char_code,
  input  logic signed [7:0]           row,
  input  logic signed [9:0]           col,
  input  logic [$clog2(MAX_ROWS)-1:0] win_row_last,
  input  logic [$clog2(MAX_COLS)-1:0] win_col_last,
  input  logic                        clear_busy,
  input  logic                        queue_full,
  output logic                        cmd_push,
  output cmd_t                        cmd,
  output logic [$clog2(MAX_ROWS)-1:0] cmd_row,
  output logic [$clog2(MAX_COLS)-1:0] cmd_col
);

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int RXW = (RIW > 7) ? RIW : 7;
  localparam int CXW = (CIW > 9) ? CIW : 9;

  logic           hold_valid;
  logic           accept;
  logic           r_big;
  logic           c_big;
  logic           r_in;
  logic           c_in;
  logic [RIW-1:0] row_fit;
  logic [CIW-1:0] col_fit;
  cmd_t           cmd_dec;

  // Stall while the store is being cleared or the held request cannot leave
  assign in_stall = clear_busy || (hold_valid && queue_full);
  assign accept   = in_valid && !in_stall;
  assign cmd_push = hold_valid && !queue_full;

  // Clamp row and column into the window
  always_comb begin
    r_big   = RXW'(row[6:0]) > RXW'(win_row_last);
    c_big   = CXW'(col[8:0]) > CXW'(win_col_last);
    r_in    = !row[7] && !r_big;
    c_in    = !col[9] && !c_big;
    row_fit = row[7] ? '0 : (r_big ? win_row_last : RIW'(row[6:0]));
    col_fit = col[9] ? '0 : (c_big ? win_col_last : CIW'(col[8:0]));
  end

  // Decode the request into one operation
  always_comb begin
    cmd_dec.ch = char_code;
    unique case (kind)
      KIND_PUT: begin
        if (char_code == CH_CR) begin
          cmd_dec.op = OP_CR;
        end else if (char_code == CH_LF) begin
          cmd_dec.op = OP_LF;
        end else begin
          cmd_dec.op = OP_CHAR;
        end
      end
      KIND_MOVE:    cmd_dec.op = OP_MOVE;
      KIND_CLR_EOL: cmd_dec.op = OP_CLR_EOL;
      KIND_ERASE:   cmd_dec.op = OP_ERASE;
      KIND_READ:    cmd_dec.op = (r_in && c_in) ? OP_READ : OP_NOP;
      default:      cmd_dec.op = OP_NOP;
    endcase
  end

  // Hold the decoded request until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= accept || (hold_valid && queue_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= cmd_dec;
      cmd_row <= row_fit;
      cmd_col <= col_fit;
    end
  end

endmodule

// ===== rtl/core/twcw_back.sv =====
// ----------------------------------------------------------------------------
// twcw_back
// Back end: owns the character store and the cursor. Simple commands finish
// in the cycle they leave the queue; clear to end of line, erase, scroll and
// read run as short sequences on the one-write, one-read store. Results go
// out through a register.
// ----------------------------------------------------------------------------
module twcw_back
  import twcw_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_pop,
  input  cmd_t                        cmd,
  input  logic [$clog2(MAX_ROWS)-1:0] cmd_row,
  input  logic [$clog2(MAX_COLS)-1:0] cmd_col,
  input  logic [$clog2(MAX_ROWS)-1:0] win_row_last,
  input  logic [$clog2(MAX_COLS)-1:0] win_col_last,
  input  logic                        scroll_en,
  output logic                        clear_busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [5:0]                  cursor_row,
  output logic [7:0]                  cursor_col,
  output logic [7:0]                  read_char
);

  localparam int RIW       = $clog2(MAX_ROWS);
  localparam int CIW       = $clog2(MAX_COLS);
  localparam int AW        = RIW + CIW;
  localparam int MEM_DEPTH = MAX_ROWS * (2 ** CIW);

  // Character store, addressed as {row, col}
  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  back_state_t state;
  back_state_t state_next;

  logic [RIW-1:0] cur_row, cur_row_next;
  logic [CIW-1:0] cur_col, cur_col_next;
  logic [RIW-1:0] fr, fr_next;
  logic [CIW-1:0] fc, fc_next;
  logic [CIW-1:0] f_col_start, f_col_start_next;
  logic [RIW-1:0] f_row_end, f_row_end_next;
  logic [CIW-1:0] f_col_end, f_col_end_next;
  logic [RIW-1:0] cr, cr_next;
  logic [CIW-1:0] cc, cc_next;
  logic           cp_pend;
  logic [RIW-1:0] cp_wrow;
  logic [CIW-1:0] cp_wcol;
  logic           res_is_read, res_is_read_next;
  logic           out_valid_next;
  logic [RIW-1:0] out_row;
  logic [CIW-1:0] out_col;
  logic [7:0]     out_rd;

  logic out_free;
  logic out_load;
  logic at_end_row;
  logic at_end_col;
  logic scroll_start;
  logic fill_last;
  logic copy_last;

  assign out_free   = !out_valid || !out_stall;
  assign at_end_row = (cur_row == win_row_last);
  assign at_end_col = (cur_col == win_col_last);
  assign fill_last  = (fc == f_col_end) && (fr == f_row_end);
  assign copy_last  = (cc == win_col_last) && (cr == win_row_last);
  assign clear_busy = (state == ST_CLEAR);

  assign cursor_row = 6'(out_row);
  assign cursor_col = 8'(out_col);
  assign read_char  = out_rd;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_pop) begin
          if ((cmd.op == OP_CLR_EOL) || (cmd.op == OP_ERASE)) begin
            state_next = ST_FILL;
          end else if (cmd.op == OP_READ) begin
            state_next = ST_READ;
          end else if (scroll_start) begin
            state_next = (win_row_last != '0) ? ST_COPY : ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (fill_last) state_next = ST_DONE;
      end
      ST_COPY: begin
        if (copy_last) state_next = ST_COPY_END;
      end
      ST_COPY_END: state_next = ST_FILL;
      ST_READ:     state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: queue pop, result load, store port controls
  always_comb begin
    cmd_pop      = (state == ST_IDLE) && cmd_valid && out_free;
    scroll_start = cmd_pop && scroll_en && at_end_row &&
                   ((cmd.op == OP_LF) || ((cmd.op == OP_CHAR) && at_end_col));
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = {fr, fc};
    mem_wdata    = CH_BLANK;
    mem_re       = 1'b0;
    mem_raddr    = {cr, cc};
    unique case (state)
      ST_CLEAR, ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        out_load = cmd_pop && !scroll_start && (cmd.op != OP_CLR_EOL) &&
                   (cmd.op != OP_ERASE) && (cmd.op != OP_READ);
        if (cmd_pop && (cmd.op == OP_CHAR)) begin
          mem_we    = 1'b1;
          mem_waddr = {cur_row, cur_col};
          mem_wdata = cmd.ch;
        end
        if (cmd_pop && (cmd.op == OP_READ)) begin
          mem_re    = 1'b1;
          mem_raddr = {cmd_row, cmd_col};
        end
      end
      ST_COPY: begin
        mem_re = 1'b1;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
    // Land the cell read in the previous copy cycle one row up
    if (cp_pend) begin
      mem_we    = 1'b1;
      mem_waddr = {cp_wrow, cp_wcol};
      mem_wdata = rdata;
    end
  end

  // Cursor, sweep counters and result bookkeeping
  always_comb begin
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    fr_next          = fr;
    fc_next          = fc;
    f_col_start_next = f_col_start;
    f_row_end_next   = f_row_end;
    f_col_end_next   = f_col_end;
    cr_next          = cr;
    cc_next          = cc;
    res_is_read_next = res_is_read;
    out_valid_next   = out_load || (out_valid && out_stall);
    unique case (state)
      ST_CLEAR, ST_FILL: begin
        // Step the blank sweep: columns inside, rows outside
        if (fc == f_col_end) begin
          fc_next = f_col_start;
          if (fr != f_row_end) fr_next = fr + RIW'(1);
        end else begin
          fc_next = fc + CIW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_pop) begin
          res_is_read_next = (cmd.op == OP_READ);
          unique case (cmd.op)
            OP_CR: begin
              cur_col_next = '0;
            end
            OP_LF: begin
              cur_col_next = '0;
              if (!at_end_row) cur_row_next = cur_row + RIW'(1);
            end
            OP_CHAR: begin
              if (!at_end_col) begin
                cur_col_next = cur_col + CIW'(1);
              end else if (!at_end_row) begin
                cur_col_next = '0;
                cur_row_next = cur_row + RIW'(1);
              end else if (scroll_en) begin
                cur_col_next = '0;
              end
            end
            OP_MOVE: begin
              cur_row_next = cmd_row;
              cur_col_next = cmd_col;
            end
            OP_CLR_EOL: begin
              fr_next          = cur_row;
              fc_next          = cur_col;
              f_col_start_next = cur_col;
              f_row_end_next   = cur_row;
              f_col_end_next   = win_col_last;
            end
            OP_ERASE: begin
              fr_next          = '0;
              fc_next          = '0;
              f_col_start_next = '0;
              f_row_end_next   = win_row_last;
              f_col_end_next   = win_col_last;
            end
            default: begin
              cur_row_next = cur_row;
            end
          endcase
          // Scroll: copy rows up, then blank the bottom row
          if (scroll_start) begin
            fr_next          = win_row_last;
            fc_next          = '0;
            f_col_start_next = '0;
            f_row_end_next   = win_row_last;
            f_col_end_next   = win_col_last;
            cr_next          = RIW'(1);
            cc_next          = '0;
          end
        end else begin
          // Pull the cursor back in after a window resize
          if (cur_row > win_row_last) cur_row_next = win_row_last;
          if (cur_col > win_col_last) cur_col_next = win_col_last;
        end
      end
      ST_COPY: begin
        if (cc == win_col_last) begin
          cc_next = '0;
          if (cr != win_row_last) cr_next = cr + RIW'(1);
        end else begin
          cc_next = cc + CIW'(1);
        end
      end
      default: begin
        cr_next = cr;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cur_row     <= '0;
      cur_col     <= '0;
      fr          <= '0;
      fc          <= '0;
      f_col_start <= '0;
      f_row_end   <= RIW'(MAX_ROWS - 1);
      f_col_end   <= CIW'(MAX_COLS - 1);
      cr          <= '0;
      cc          <= '0;
      cp_pend     <= 1'b0;
      res_is_read <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cur_row     <= cur_row_next;
      cur_col     <= cur_col_next;
      fr          <= fr_next;
      fc          <= fc_next;
      f_col_start <= f_col_start_next;
      f_row_end   <= f_row_end_next;
      f_col_end   <= f_col_end_next;
      cr          <= cr_next;
      cc          <= cc_next;
      cp_pend     <= (state == ST_COPY);
      res_is_read <= res_is_read_next;
      out_valid   <= out_valid_next;
    end
  end

  // Copy write-back address trails the read into the next cycle
  always_ff @(posedge clk) begin
    cp_wrow <= cr - RIW'(1);
    cp_wcol <= cc;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row <= cur_row_next;
      out_col <= cur_col_next;
      out_rd  <= ((state == ST_DONE) && res_is_read) ? rdata : 8'd0;
    end
  end

  // Character store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // A command leaves the queue only when its result has somewhere to go
  a_pop_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (!out_valid || !out_stall))
    else $error("command popped while result register is blocked");

  // No command is taken during the power-up clearing pass
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !cmd_pop)
    else $error("command popped during clearing pass");

  // Blank sweep stays within its bounds
  a_fill_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> ((fr <= f_row_end) && (fc <= f_col_end) &&
                            (fc >= f_col_start)))
    else $error("fill sweep out of bounds");

  // Copy write-back only follows a copy read
  a_copy_follows_read: assert property (@(posedge clk) disable iff (rst)
    cp_pend |-> ($past(state) == ST_COPY))
    else $error("copy write without preceding read");

endmodule

// ===== rtl/core/text_window_char_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_window_char_writer_top
// Character-cell text window with cursor, wrap and optional scrolling.
//
//   channel  direction  handshake                payload
//   in       input      in_valid / in_stall      kind, char_code, row, col
//   out      output     out_valid / out_stall    cursor_row, cursor_col,
//                                                read_char
//   cfg      input      cfg_we                   cfg_index, cfg_data
//
// Carriage return, move, no-op and a character or line feed that does not
// scroll are taken one per cycle while out does not stall. Read cell, clear
// to end of line, erase and scroll run as sequences on the store, which has
// one write port; in a one-row window scroll only blanks the bottom row.
// Reset blanks all MAX_ROWS*MAX_COLS cells with in_stall high.
// Out stalls hold the result register; in stalls come from a full queue or the clearing pass.
// ----------------------------------------------------------------------------
module text_window_char_writer_top
  import twcw_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     kind,
  input  logic [7:0]            char_code,
  input  logic signed [7:0]     row,
  input  logic signed [9:0]     col,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [5:0]            cursor_row,
  output logic [7:0]            cursor_col,
  output logic [7:0]            read_char
);

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int RXW = (RIW + 1 > ROWS_CFG_W) ? RIW + 1 : ROWS_CFG_W;
  localparam int CXW = (CIW + 1 > COLS_CFG_W) ? CIW + 1 : COLS_CFG_W;
  localparam int QW  = CMD_W + RIW + CIW;

  logic [ROWS_CFG_W-1:0] rows_in_use;
  logic [COLS_CFG_W-1:0] cols_in_use;
  logic                  scroll_enable;

  logic [RXW-1:0] rows_x;
  logic [CXW-1:0] cols_x;
  logic [RIW-1:0] win_row_last;
  logic [CIW-1:0] win_col_last;

  logic           clear_busy;
  logic           queue_full;
  logic           cmd_push;
  cmd_t           f_cmd;
  logic [RIW-1:0] f_row;
  logic [CIW-1:0] f_col;
  logic           q_valid;
  logic           q_pop;
  logic [QW-1:0]  q_dout;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use   <= ROWS_RESET;
      cols_in_use   <= COLS_RESET;
      scroll_enable <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROWS) rows_in_use <= cfg_data[ROWS_CFG_W-1:0];
      if (cfg_index == CFG_COLS) cols_in_use <= cfg_data[COLS_CFG_W-1:0];
      if (cfg_index == CFG_SCROLL) scroll_enable <= cfg_data[0];
    end
  end

  // Saturate the window size into 1..MAX and form the last row and column
  always_comb begin
    rows_x = RXW'(rows_in_use);
    cols_x = CXW'(cols_in_use);
    if (rows_in_use == '0) begin
      win_row_last = '0;
    end else if (rows_x > RXW'(MAX_ROWS)) begin
      win_row_last = RIW'(MAX_ROWS - 1);
    end else begin
      win_row_last = RIW'(rows_x - RXW'(1));
    end
    if (cols_in_use == '0) begin
      win_col_last = '0;
    end else if (cols_x > CXW'(MAX_COLS)) begin
      win_col_last = CIW'(MAX_COLS - 1);
    end else begin
      win_col_last = CIW'(cols_x - CXW'(1));
    end
  end

  twcw_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .char_code   (char_code),
    .row         (row),
    .col         (col),
    .win_row_last(win_row_last),
    .win_col_last(win_col_last),
    .clear_busy  (clear_busy),
    .queue_full  (queue_full),
    .cmd_push    (cmd_push),
    .cmd         (f_cmd),
    .cmd_row     (f_row),
    .cmd_col     (f_col)
  );

  twcw_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .din  ({f_cmd, f_row, f_col}),
    .full (queue_full),
    .valid(q_valid),
    .pop  (q_pop),
    .dout (q_dout)
  );

  twcw_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .cmd         (cmd_t'(q_dout[QW-1 -: CMD_W])),
    .cmd_row     (q_dout[RIW+CIW-1 -: RIW]),
    .cmd_col     (q_dout[CIW-1:0]),
    .win_row_last(win_row_last),
    .win_col_last(win_col_last),
    .scroll_en   (scroll_enable),
    .clear_busy  (clear_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cursor_row  (cursor_row),
    .cursor_col  (cursor_col),
    .read_char   (read_char)
  );

endmodule
